### src/rxfet_pkg.sv
// ----------------------------------------------------------------------------
// rxfet_pkg
// shared types and constants of the receive ring buffer with event trigger
// ----------------------------------------------------------------------------
package rxfet_pkg;

  localparam int unsigned DepthDef  = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FillW     = 6;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [ByteW-1:0] TermCharRst  = 8'd10;
  localparam logic [FillW-1:0] SizeThrRst   = 6'd1;

  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SIZE_EN  = 2'd0,
    CFG_SIZE_THR = 2'd1,
    CFG_TERM_EN  = 2'd2,
    CFG_TERM_CHR = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH
  } state_e;

  typedef struct packed {
    logic latch;
    logic rd_issue;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_fetch;
    logic out_free;
  } dp_stat_t;

endpackage

### src/rxfet_ram.sv
// ----------------------------------------------------------------------------
// rxfet_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rxfet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rxfet_ctrl.sv
// ----------------------------------------------------------------------------
// rxfet_ctrl
// sequencer: takes one beat, runs it through the datapath, hands off result
// ----------------------------------------------------------------------------
module rxfet_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rxfet_pkg::dp_stat_t   stat_i,
  output rxfet_pkg::ctrl_cmd_t  cmd_o
);

  rxfet_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rxfet_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rxfet_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rxfet_pkg::ST_EXEC;
        end
      end
      rxfet_pkg::ST_EXEC: begin
        if (stat_i.needs_fetch) begin
          state_d = rxfet_pkg::ST_FETCH;
        end else if (stat_i.out_free) begin
          state_d = rxfet_pkg::ST_IDLE;
        end
      end
      rxfet_pkg::ST_FETCH: begin
        if (stat_i.out_free) begin
          state_d = rxfet_pkg::ST_IDLE;
        end
      end
      default: state_d = rxfet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      rxfet_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      rxfet_pkg::ST_EXEC: begin
        cmd_o.rd_issue = stat_i.needs_fetch;
        cmd_o.commit   = !stat_i.needs_fetch && stat_i.out_free;
      end
      rxfet_pkg::ST_FETCH: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == rxfet_pkg::ST_EXEC)
    else $error("accepted beat did not start execution");
  a_fetch_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> state_q == rxfet_pkg::ST_FETCH)
    else $error("ring read not followed by fetch");
  a_commit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> state_q == rxfet_pkg::ST_IDLE)
    else $error("commit did not return to idle");
`endif

endmodule

### src/rxfet_dp.sv
// ----------------------------------------------------------------------------
// rxfet_dp
// ring pointers, config registers, event logic and output register
// ----------------------------------------------------------------------------
module rxfet_dp #(
  parameter int unsigned DEPTH = rxfet_pkg::DepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rxfet_pkg::ctrl_cmd_t                cmd_i,
  output rxfet_pkg::dp_stat_t                 stat_o,
  input  logic [1:0]                          in_op_i,
  input  logic [rxfet_pkg::ByteW-1:0]         in_byte_i,
  input  logic                                cfg_we_i,
  input  logic [rxfet_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [rxfet_pkg::CfgDataW-1:0]      cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rxfet_pkg::ByteW-1:0]         out_byte_o,
  output logic                                out_dvalid_o,
  output logic [rxfet_pkg::FillW-1:0]         out_fill_o,
  output logic                                out_event_o,
  output logic                                out_ovf_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned FW = rxfet_pkg::FillW;
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
  localparam logic [PW:0]   DepthW  = (PW + 1)'(DEPTH);

  rxfet_pkg::op_e              op_q;
  logic [rxfet_pkg::ByteW-1:0] byte_q;
  logic [PW-1:0]               wp_q, wp_d, rp_q, rp_d;

  logic                        size_en_q, term_en_q;
  logic [FW-1:0]               size_thr_q;
  logic [rxfet_pkg::ByteW-1:0] term_chr_q;

  logic                        out_valid_q;
  logic [rxfet_pkg::ByteW-1:0] out_byte_q;
  logic                        out_dvalid_q, out_event_q, out_ovf_q;
  logic [FW-1:0]               out_fill_q;

  logic [PW-1:0]               wp_nxt, rp_nxt, cnt;
  logic [PW:0]                 cnt_sum;
  logic [PW+FW-1:0]            cnt_wide;
  logic                        empty, full, is_read, ram_we;
  logic                        by_size, by_term, ev;
  logic [rxfet_pkg::ByteW-1:0] ram_rdata;

  assign wp_nxt  = (wp_q == PtrLast) ? '0 : wp_q + PW'(1);
  assign rp_nxt  = (rp_q == PtrLast) ? '0 : rp_q + PW'(1);
  assign empty   = (wp_q == rp_q);
  assign full    = (wp_nxt == rp_q);
  assign is_read = (op_q == rxfet_pkg::OP_POP) || (op_q == rxfet_pkg::OP_PEEK);
  assign ram_we  = cmd_i.commit && (op_q == rxfet_pkg::OP_RECV) && !full;

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    case (op_q)
      rxfet_pkg::OP_RECV:  if (!full) wp_d = wp_nxt;
      rxfet_pkg::OP_POP:   if (!empty) rp_d = rp_nxt;
      rxfet_pkg::OP_PEEK:  rp_d = rp_q;
      rxfet_pkg::OP_CLEAR: rp_d = wp_q;
      default:             rp_d = rp_q;
    endcase
  end

  // fill count after the operation, mod depth
  assign cnt_sum  = {1'b0, wp_d} + ((wp_d < rp_d) ? DepthW : '0) - {1'b0, rp_d};
  assign cnt      = cnt_sum[PW-1:0];
  assign cnt_wide = {{FW{1'b0}}, cnt};

  assign by_size = size_en_q && (cnt_wide >= {{PW{1'b0}}, size_thr_q});
  assign by_term = term_en_q && (byte_q == term_chr_q);
  assign ev      = (op_q == rxfet_pkg::OP_RECV) && !full &&
                   (by_size || by_term || (!size_en_q && !term_en_q));

  assign stat_o.needs_fetch = is_read && !empty;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  rxfet_ram #(
    .WIDTH (rxfet_pkg::ByteW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_nxt),
    .wdata_i (byte_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rp_nxt),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= rxfet_pkg::op_e'(in_op_i);
      byte_q <= in_byte_i;
    end
    if (cmd_i.commit) begin
      out_byte_q   <= (is_read && !empty) ? ram_rdata : '0;
      out_dvalid_q <= is_read && !empty;
      out_fill_q   <= cnt_wide[FW-1:0];
      out_event_q  <= ev;
      out_ovf_q    <= (op_q == rxfet_pkg::OP_RECV) && full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        wp_q <= wp_d;
        rp_q <= rp_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_en_q  <= 1'b0;
      size_thr_q <= rxfet_pkg::SizeThrRst;
      term_en_q  <= 1'b0;
      term_chr_q <= rxfet_pkg::TermCharRst;
    end else if (cfg_we_i) begin
      case (rxfet_pkg::cfg_reg_e'(cfg_index_i))
        rxfet_pkg::CFG_SIZE_EN:  size_en_q  <= cfg_data_i[0];
        rxfet_pkg::CFG_SIZE_THR: size_thr_q <= cfg_data_i[FW-1:0];
        rxfet_pkg::CFG_TERM_EN:  term_en_q  <= cfg_data_i[0];
        rxfet_pkg::CFG_TERM_CHR: term_chr_q <= cfg_data_i;
        default:                 size_en_q  <= size_en_q;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_dvalid_o = out_dvalid_q;
  assign out_fill_o   = out_fill_q;
  assign out_event_o  = out_event_q;
  assign out_ovf_o    = out_ovf_q;

`ifndef SYNTHESIS
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> stat_o.out_free)
    else $error("result committed over an untaken result");
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_ovf_q && out_event_q) && !(out_dvalid_q && out_ovf_q))
    else $error("conflicting result flags");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && op_q == rxfet_pkg::OP_CLEAR) |=> (wp_q == rp_q) && out_fill_q == '0)
    else $error("clear left bytes in the ring");
`endif

endmodule

### src/rx_fifo_event_trigger.sv
// ----------------------------------------------------------------------------
// rx_fifo_event_trigger
// receive ring buffer with size and terminator event trigger
// ----------------------------------------------------------------------------
//  channel   direction  tdata / payload                     tuser
//  s_axis    in         rx_byte                             opcode
//  m_axis    out        data_byte, fill_count, event, ovf   data_valid
//  cfg       in         index, write data                   -
//
//  receive, clear and pop/peek on an empty ring commit in the exec state; a
//  pop/peek that finds a byte commits in a fetch state, after the ring read.
//  one beat is in work at a time; a new beat is taken while the result
//  register still waits on m_axis_tready.
//  reset clears pointers, cfg, out valid; the ring memory is not cleared.
//  cfg beats are always taken.
// ----------------------------------------------------------------------------
module rx_fifo_event_trigger #(
  parameter int unsigned DEPTH = rxfet_pkg::DepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // rx_byte
  input  logic [1:0]                        s_axis_tuser,   // opcode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // data_byte[7:0], fill_count[13:8], event_res[14], overflow[15]
  output logic [15:0]                       m_axis_tdata,
  output logic [0:0]                        m_axis_tuser,   // data_valid
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rxfet_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [rxfet_pkg::CfgDataW-1:0]    cfg_data_i
);

  rxfet_pkg::ctrl_cmd_t        cmd;
  rxfet_pkg::dp_stat_t         stat;
  logic [rxfet_pkg::ByteW-1:0] out_byte;
  logic [rxfet_pkg::FillW-1:0] out_fill;
  logic                        out_dvalid, out_event, out_ovf;

  assign cfg_ready_o = 1'b1;

  rxfet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rxfet_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_op_i      (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .out_dvalid_o (out_dvalid),
    .out_fill_o   (out_fill),
    .out_event_o  (out_event),
    .out_ovf_o    (out_ovf)
  );

  assign m_axis_tdata = {out_ovf, out_event, out_fill, out_byte};
  assign m_axis_tuser = out_dvalid;

endmodule

### tb/rx_ring_checker.sv
// ----------------------------------------------------------------------------
// rx_ring_checker
// watches the stream and cfg channels of the receive ring buffer, keeps its own
// copy of the ring, pointers and trigger registers, predicts the result of
// every accepted input beat and compares each result beat field by field
// ----------------------------------------------------------------------------
module rx_ring_checker
  import rxfet_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // rx_byte
  input  logic [1:0]           s_axis_tuser,   // opcode
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // data_byte[7:0], fill_count[13:8], event_res[14], overflow[15]
  input  logic [15:0]          m_axis_tdata,
  input  logic [0:0]           m_axis_tuser,   // data_valid
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int unsigned          mismatch_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PtrW = $clog2(DepthDef);

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             data_valid;
    logic [FillW-1:0] fill_count;
    logic             event_res;
    logic             overflow;
  } ring_result_t;

  logic [ByteW-1:0] ring_mem [DepthDef];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic             size_en;
  logic [FillW-1:0] size_thr;
  logic             term_en;
  logic [ByteW-1:0] term_chr;

  ring_result_t expected_q [$];
  int unsigned  mismatches = 0;

  function automatic ring_result_t ring_apply(op_e op, logic [ByteW-1:0] rx);
    ring_result_t res;
    logic [PtrW-1:0] nxt;
    res = '0;
    case (op)
      OP_RECV: begin
        nxt = wr_ptr + 1'b1;
        if (nxt == rd_ptr) begin
          res.overflow = 1'b1;
        end else begin
          wr_ptr = nxt;
          ring_mem[nxt] = rx;
          res.event_res = (size_en && FillW'(wr_ptr - rd_ptr) >= size_thr) ||
                          (term_en && rx == term_chr) || (!size_en && !term_en);
        end
      end
      OP_POP, OP_PEEK: begin
        if (wr_ptr != rd_ptr) begin
          nxt = rd_ptr + 1'b1;
          res.data_byte  = ring_mem[nxt];
          res.data_valid = 1'b1;
          if (op == OP_POP) rd_ptr = nxt;
        end
      end
      default: begin
        rd_ptr = wr_ptr;
      end
    endcase
    res.fill_count = FillW'(wr_ptr - rd_ptr);
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ring_result_t exp_r;
    if (!rst_ni) begin
      wr_ptr   = '0;
      rd_ptr   = '0;
      size_en  = 1'b0;
      size_thr = SizeThrRst;
      term_en  = 1'b0;
      term_chr = TermCharRst;
      expected_q.delete();
      pending_o  <= 0;
      mismatch_o <= mismatches;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("data_byte", exp_r.data_byte, m_axis_tdata[7:0]);
          check_field("data_valid", 8'(exp_r.data_valid), 8'(m_axis_tuser[0]));
          check_field("fill_count", 8'(exp_r.fill_count), 8'(m_axis_tdata[13:8]));
          check_field("event_res", 8'(exp_r.event_res), 8'(m_axis_tdata[14]));
          check_field("overflow", 8'(exp_r.overflow), 8'(m_axis_tdata[15]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(ring_apply(op_e'(s_axis_tuser), s_axis_tdata));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SIZE_EN:  size_en  = cfg_data_i[0];
          CFG_SIZE_THR: size_thr = cfg_data_i[FillW-1:0];
          CFG_TERM_EN:  term_en  = cfg_data_i[0];
          CFG_TERM_CHR: term_chr = cfg_data_i[ByteW-1:0];
          default: ;
        endcase
      end
      pending_o  <= expected_q.size();
      mismatch_o <= mismatches;
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the receive ring buffer with event trigger: a short directed
// run over empty, clear and trigger corner cases, then phases of random
// operation mixes under several trigger settings, with bursty input, a
// stalling output side and a result checker beside the block
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rxfet_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseItems  = 130;
  localparam int unsigned FloodItems  = 75;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned TailCycles  = 10;

  typedef enum logic [1:0] {
    MIX_FLOOD,
    MIX_FILL,
    MIX_DRAIN,
    MIX_BLEND
  } op_mix_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = OP_RECV;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = CFG_SIZE_EN;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  int unsigned mismatch_count;
  int unsigned pending;

  logic [7:0]  term_now = TermCharRst;
  int unsigned burst_left = 1;
  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned pat_age = 0;
  logic [15:0] ready_pat = '1;
  int unsigned idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rx_fifo_event_trigger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  rx_ring_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatch_o    (mismatch_count),
    .pending_o     (pending)
  );

  // output side: one long hold-off on request, else a rotating ready pattern
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt  = LongHold;
      hold_done = 1'b1;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = '1;
          1: ready_pat = 16'($urandom);
          2: ready_pat = 16'($urandom) & 16'($urandom);
          default: ready_pat = 16'($urandom) | 16'($urandom);
        endcase
      end
      pat_age = (pat_age + 1) % 64;
      m_axis_tready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic op_e pick_op(op_mix_e mix);
    int unsigned r;
    int unsigned recv_lim;
    int unsigned pop_lim;
    int unsigned peek_lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FLOOD: begin recv_lim = 96; pop_lim = 98; peek_lim = 99; end
      MIX_FILL:  begin recv_lim = 80; pop_lim = 92; peek_lim = 98; end
      MIX_DRAIN: begin recv_lim = 20; pop_lim = 80; peek_lim = 97; end
      default:   begin recv_lim = 45; pop_lim = 78; peek_lim = 94; end
    endcase
    if (r < recv_lim) return OP_RECV;
    if (r < pop_lim) return OP_POP;
    if (r < peek_lim) return OP_PEEK;
    return OP_CLEAR;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return term_now;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(op_e op, logic [7:0] rx);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= rx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(logic se, logic [5:0] thr, logic te, logic [7:0] tc);
    cfg_reg_e r;
    r = r.first();
    do begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      case (r)
        CFG_SIZE_EN:  cfg_data_i <= {7'($urandom), se};
        CFG_SIZE_THR: cfg_data_i <= {2'($urandom), thr};
        CFG_TERM_EN:  cfg_data_i <= {7'($urandom), te};
        default:      cfg_data_i <= tc;
      endcase
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_valid_i <= 1'b0;
    term_now = tc;
  endtask

  initial begin
    int unsigned n;
    int unsigned seg;
    op_mix_e     mix;
    logic        se;
    logic [5:0]  thr;
    logic        te;
    logic [7:0]  tc;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: both triggers off, every stored byte raises an event
    send_item(OP_PEEK, 8'h00);
    send_item(OP_POP, 8'hFF);
    send_item(OP_RECV, 8'h00);
    send_item(OP_RECV, 8'hFF);
    send_item(OP_RECV, 8'h0A);
    send_item(OP_PEEK, 8'h5A);
    send_item(OP_POP, 8'hA5);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'hFF);
    send_item(OP_POP, 8'h00);
    send_item(OP_RECV, 8'h55);
    send_item(OP_RECV, 8'hAA);
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_PEEK, 8'h00);
    send_item(OP_CLEAR, 8'h00);

    // size trigger with threshold zero
    wait_drain();
    program_regs(1'b1, 6'd0, 1'b0, 8'h0A);
    send_item(OP_RECV, 8'h80);
    send_item(OP_RECV, 8'h7F);
    send_item(OP_CLEAR, 8'h00);

    // both triggers, terminator at the top of the byte range
    wait_drain();
    program_regs(1'b1, 6'd2, 1'b1, 8'hFF);
    send_item(OP_RECV, 8'h00);
    send_item(OP_RECV, 8'hFF);
    send_item(OP_RECV, 8'h11);
    send_item(OP_POP, 8'h00);
    send_item(OP_CLEAR, 8'h00);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin se = 1'b0; thr = SizeThrRst; te = 1'b0; tc = TermCharRst; end
        1: begin se = 1'b1; thr = 6'd63; te = 1'b0; tc = 8'h00; end
        2: begin se = 1'b1; thr = 6'd0; te = 1'b1; tc = 8'hFF; end
        3: begin se = 1'b0; thr = 6'd63; te = 1'b1; tc = 8'h00; end
        4: begin se = 1'b1; thr = 6'd32; te = 1'b1; tc = 8'hFF; end
        default: begin
          se  = 1'($urandom);
          thr = 6'($urandom_range(0, 63));
          te  = 1'($urandom);
          tc  = 8'($urandom);
        end
      endcase
      wait_drain();
      program_regs(se, thr, te, tc);
      if (p == 3) hold_req <= 1'b1;
      n = 0;
      while (n < PhaseItems) begin
        if (n == 0 && p % 2 == 0) begin
          mix = MIX_FLOOD;
          seg = FloodItems;
        end else begin
          mix = op_mix_e'($urandom_range(1, 3));
          seg = $urandom_range(8, 40);
        end
        for (int k = 0; k < seg && n < PhaseItems; k++) begin
          if (p == 1 && n == PhaseItems / 2) wait_drain();
          send_item(pick_op(mix), pick_byte());
          n++;
        end
      end
    end

    wait_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
